>>> rtl/pvd_pkg.sv
// pvd_pkg: shared types and constants for the polynomial value/derivative block
// no dependencies
`default_nettype none
package pvd_pkg;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_TERM_COUNT = 3'd0;

    localparam logic OP_VALUE = 1'b0;
    localparam logic OP_DERIV = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] point;
        logic                     opcode;
    } pvd_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     overflow;
    } pvd_out_t;

    // saturate a 35-bit signed value to 32 bits
    function automatic logic [DATA_W:0] sat35(input logic signed [34:0] v);
        logic [DATA_W:0] r;
        if (v > 35'sd2147483647)
        begin
            r = {1'b1, 32'h7fff_ffff};
        end
        else if (v < -35'sd2147483648)
        begin
            r = {1'b1, 32'h8000_0000};
        end
        else
        begin
            r = {1'b0, v[DATA_W-1:0]};
        end
        return r;
    endfunction
endpackage
`default_nettype wire

>>> rtl/pvd_if.sv
// pvd_if: valid/ready channel carrying one word of a generic payload type
// depends on nothing beyond the payload type given as parameter
`default_nettype none
interface pvd_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/pvd_stage.sv
// pvd_stage: one term of the evaluation, spread over three register stages
// depends on pvd_pkg
`default_nettype none
module pvd_stage
    import pvd_pkg::*;
#(
    parameter int unsigned TERM      = 0,
    parameter int unsigned FRAC_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     active,     // this term takes part
    input  wire logic                     more,       // another term follows
    input  wire logic signed [DATA_W-1:0] coeff,
    input  wire logic                     v_in,
    input  wire logic signed [DATA_W-1:0] x_in,
    input  wire logic signed [DATA_W-1:0] xp_in,
    input  wire logic signed [DATA_W-1:0] sum_in,
    input  wire logic                     op_in,
    input  wire logic                     ovf_in,
    output logic                          v_out,
    output logic signed [DATA_W-1:0]      x_out,
    output logic signed [DATA_W-1:0]      xp_out,
    output logic signed [DATA_W-1:0]      sum_out,
    output logic                          op_out,
    output logic                          ovf_out
);
    localparam int unsigned PW = 2 * DATA_W;
    localparam int unsigned MW = TERM < 2 ? 1 : $clog2(TERM + 1);

    logic [2:0] v_reg;
    logic signed [DATA_W-1:0] x_reg [3];
    logic signed [DATA_W-1:0] sum_reg [2];
    logic op_reg [3];
    logic ovf_reg [2];
    logic act_reg [2];
    logic more_reg;
    logic signed [PW-1:0] pt_reg, pp_reg;
    logic signed [DATA_W-1:0] xp0_reg;
    logic signed [DATA_W-1:0] ts_reg;
    logic                     tovf_reg;
    logic signed [DATA_W-1:0] xp1_reg;

    logic signed [PW-1:0] pt_sh, pp_sh, pt_cl, pt_mul;
    logic signed [34:0]   sum_wide;
    logic [DATA_W:0]      tsat, ssat, psat;
    logic                 use_term;
    logic                 skip_pow;

    // stage 1: both products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], v_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg     <= PW'(xp_in) * PW'(coeff);
            pp_reg     <= PW'(xp_in) * PW'(x_in);
            xp0_reg    <= xp_in;
            x_reg[0]   <= x_in;
            sum_reg[0] <= sum_in;
            op_reg[0]  <= op_in;
            ovf_reg[0] <= ovf_in;
            act_reg[0] <= active;
            more_reg   <= more;
            x_reg[1]   <= x_reg[0];
            op_reg[1]  <= op_reg[0];
            sum_reg[1] <= sum_reg[0];
            act_reg[1] <= act_reg[0] && !skip_pow;
            ovf_reg[1] <= ovf_reg[0] || (more_reg && !skip_pow && psat[DATA_W]);
            ts_reg     <= tsat[DATA_W-1:0];
            tovf_reg   <= tsat[DATA_W];
            xp1_reg    <= !more_reg ? '0 : (skip_pow ? xp0_reg : psat[DATA_W-1:0]);
            x_reg[2]   <= x_reg[1];
            op_reg[2]  <= op_reg[1];
            xp_out     <= xp1_reg;
            sum_out    <= use_term ? ssat[DATA_W-1:0] : sum_reg[1];
            ovf_out    <= ovf_reg[1] || (use_term && (tovf_reg || ssat[DATA_W]));
        end
    end

    // stage 2: shift, clamp and scale by term index (derivative only), saturate
    always_comb
    begin
        // derivative has no constant term, so the power stays at one here
        skip_pow = (op_reg[0] == OP_DERIV) && (TERM == 0);
        pt_sh = pt_reg >>> FRAC_BITS;
        pp_sh = pp_reg >>> FRAC_BITS;
        pt_cl = pt_sh;
        if (op_reg[0] == OP_DERIV)
        begin
            if (pt_sh > (PW'(1) <<< 40))
            begin
                pt_cl = PW'(1) <<< 40;
            end
            else if (pt_sh < -(PW'(1) <<< 40))
            begin
                pt_cl = -(PW'(1) <<< 40);
            end
        end
        pt_mul = (op_reg[0] == OP_DERIV) ? pt_cl * PW'($unsigned(MW'(TERM))) : pt_sh;
        if (pt_mul > PW'(2147483647))
        begin
            tsat = {1'b1, 32'h7fff_ffff};
        end
        else if (pt_mul < -PW'(64'sd2147483648))
        begin
            tsat = {1'b1, 32'h8000_0000};
        end
        else
        begin
            tsat = {1'b0, pt_mul[DATA_W-1:0]};
        end
        if (pp_sh > PW'(2147483647))
        begin
            psat = {1'b1, 32'h7fff_ffff};
        end
        else if (pp_sh < -PW'(64'sd2147483648))
        begin
            psat = {1'b1, 32'h8000_0000};
        end
        else
        begin
            psat = {1'b0, pp_sh[DATA_W-1:0]};
        end
        // stage 3: accumulate
        use_term = act_reg[1];
        sum_wide = 35'(sum_reg[1]) + 35'(ts_reg);
        ssat = sat35(sum_wide);
    end

    assign v_out  = v_reg[2];
    assign x_out  = x_reg[2];
    assign op_out = op_reg[2];
endmodule
`default_nettype wire

>>> rtl/polynomial_value_and_derivative.sv
// polynomial_value_and_derivative: top level, fixed-point polynomial or derivative
// depends on pvd_pkg, pvd_if, pvd_stage
// Evaluates p(x) or p'(x) in signed Q16.16 for up to seven terms. Each term has
// its own three-stage section (products, shift/saturate, accumulate), chained in
// ascending powers; a new word is accepted every cycle unless the output stalls,
// and the whole pipe holds on a stalled output.
// Configuration (term_count, coeff_0..6) is to be written by the user only while the pipe is empty; not enforced.
`default_nettype none
module polynomial_value_and_derivative
    import pvd_pkg::*;
#(
    parameter int unsigned MAX_TERMS = 7,
    parameter int unsigned FRAC_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data,
    pvd_if.sink                    in_ch,
    pvd_if.source                  out_ch
);
    logic [2:0] term_count_reg;
    logic signed [DATA_W-1:0] coeff_reg [MAX_TERMS];
    logic [2:0] n_eff;
    logic en;

    logic                     v_c   [MAX_TERMS+1];
    logic signed [DATA_W-1:0] x_c   [MAX_TERMS+1];
    logic signed [DATA_W-1:0] xp_c  [MAX_TERMS+1];
    logic signed [DATA_W-1:0] sum_c [MAX_TERMS+1];
    logic                     op_c  [MAX_TERMS+1];
    logic                     ovf_c [MAX_TERMS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= '0;
            for (int i = 0; i < MAX_TERMS; i++)
            begin
                coeff_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TERM_COUNT)
            begin
                term_count_reg <= cfg_data[2:0];
            end
            for (int i = 0; i < MAX_TERMS; i++)
            begin
                if (32'(cfg_index) == 32'(i + 1))
                begin
                    coeff_reg[i] <= cfg_data;
                end
            end
        end
    end

    // clamp count to the built number of terms
    assign n_eff = (32'(term_count_reg) > MAX_TERMS) ? 3'(MAX_TERMS) : term_count_reg;

    // the pipe moves whenever the output slot is empty or being taken
    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    assign v_c[0]   = in_ch.valid;
    assign x_c[0]   = in_ch.data.point;
    assign xp_c[0]  = DATA_W'(1) <<< FRAC_BITS;
    assign sum_c[0] = '0;
    assign op_c[0]  = in_ch.data.opcode;
    assign ovf_c[0] = 1'b0;

    for (genvar t = 0; t < MAX_TERMS; t++)
    begin : g_term
        pvd_stage #(.TERM(t), .FRAC_BITS(FRAC_BITS)) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .active  (32'(n_eff) > t),
            .more    (32'(n_eff) > t + 1),
            .coeff   (coeff_reg[t]),
            .v_in    (v_c[t]),
            .x_in    (x_c[t]),
            .xp_in   (xp_c[t]),
            .sum_in  (sum_c[t]),
            .op_in   (op_c[t]),
            .ovf_in  (ovf_c[t]),
            .v_out   (v_c[t+1]),
            .x_out   (x_c[t+1]),
            .xp_out  (xp_c[t+1]),
            .sum_out (sum_c[t+1]),
            .op_out  (op_c[t+1]),
            .ovf_out (ovf_c[t+1])
        );
    end

    // last section's registers are the output slot
    assign out_ch.valid             = v_c[MAX_TERMS];
    assign out_ch.data.result_value = sum_c[MAX_TERMS];
    assign out_ch.data.overflow     = ovf_c[MAX_TERMS];

`ifndef ASSERT_OFF
    // a stalled result word holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed under stall");
    // input is taken exactly when the pipe advances
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == (!out_ch.valid || out_ch.ready))
        else $error("ready does not follow pipe enable");
`endif
endmodule
`default_nettype wire

>>> tb/polynomial_value_and_derivative_tb.sv
// polynomial_value_and_derivative_tb: self-checking bench for the fixed-point polynomial block
// depends on pvd_pkg, pvd_if and the rtl top level polynomial_value_and_derivative
`default_nettype none
module polynomial_value_and_derivative_tb;
    import pvd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TERMS_MAX = 7;
    localparam int FRAC = 16;
    localparam int PIPE_DEPTH = 3 * TERMS_MAX;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;
    localparam longint PROD_LIM = 64'sd1 << 40;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    pvd_if #(.payload_t(pvd_in_t)) in_ch ();
    pvd_if #(.payload_t(pvd_out_t)) out_ch ();

    polynomial_value_and_derivative dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #5 clk = ~clk;

    // shadow copy of the configuration registers
    logic [2:0] shadow_count = '0;
    logic signed [31:0] shadow_coeff [TERMS_MAX];

    pvd_in_t points_to_send [$];
    pvd_out_t poly_expected [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int cycles = 0;

    // arithmetic shift right of an exact 64-bit product, toward minus infinity
    function automatic longint q_mul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> FRAC;
    endfunction

    function automatic longint clip32(longint v, ref bit sat);
        if (v > S32_HI)
        begin
            sat = 1'b1;
            return S32_HI;
        end
        if (v < S32_LO)
        begin
            sat = 1'b1;
            return S32_LO;
        end
        return v;
    endfunction

    // value or derivative at x, accumulated in ascending powers
    function automatic pvd_out_t poly_eval(pvd_in_t w);
        pvd_out_t r;
        bit sat;
        longint acc, xpow, x, term;
        int n;
        sat = 1'b0;
        acc = 0;
        xpow = 64'sd1 << FRAC;
        x = longint'(w.point);
        n = (shadow_count > TERMS_MAX) ? TERMS_MAX : shadow_count;
        for (int i = (w.opcode == OP_DERIV) ? 1 : 0; i < n; i++)
        begin
            term = q_mul(xpow, longint'(shadow_coeff[i]));
            if (w.opcode == OP_DERIV)
            begin
                // shift comes before the multiply by the power index
                if (term > PROD_LIM) term = PROD_LIM;
                if (term < -PROD_LIM) term = -PROD_LIM;
                term = term * i;
            end
            term = clip32(term, sat);
            acc = clip32(acc + term, sat);
            if (i + 1 < n) xpow = clip32(q_mul(xpow, x), sat);
        end
        r.result_value = acc[31:0];
        r.overflow = sat;
        return r;
    endfunction

    // driver: one word per handshake, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end
        else
        begin
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    poly_expected.push_back(poly_eval(in_ch.data));
                    void'(points_to_send.pop_front());
                end
                if (points_to_send.size() > 0
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.data <= points_to_send[0];
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        pvd_out_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (poly_expected.size() == 0)
            begin
                $error("result_value: no word expected, got %0d", out_ch.data.result_value);
                errors++;
            end
            else
            begin
                want = poly_expected.pop_front();
                if (out_ch.data.result_value !== want.result_value)
                begin
                    $error("result_value: expected %0d actual %0d",
                           want.result_value, out_ch.data.result_value);
                    errors++;
                end
                if (out_ch.data.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b actual %0b",
                           want.overflow, out_ch.data.overflow);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL polynomial_value_and_derivative");
            $finish;
        end
    end

    // write enable stays high across back-to-back writes; the caller drops it
    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == REG_TERM_COUNT)
            shadow_count = val[2:0];
        else
            shadow_coeff[idx - 1] = val;
    endtask

    // wait until the queue drains and the pipe is empty
    task automatic drain();
        while (points_to_send.size() > 0 || in_ch.valid || poly_expected.size() > 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
        endcase
    endfunction

    function automatic pvd_in_t rand_point();
        pvd_in_t w;
        case ($urandom_range(4))
            0: w.point = $urandom;
            1: w.point = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: w.point = 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        endcase
        w.opcode = $urandom_range(1);
        return w;
    endfunction

    task automatic load_coeffs(input int count, input int style);
        reg_write(REG_TERM_COUNT, 32'(count));
        for (int i = 1; i <= TERMS_MAX; i++)
            reg_write(i[IDX_W-1:0], style == 0 ? rand_coeff()
                                   : (style == 1 ? 32'h7fff_ffff : 32'h8000_0000));
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        pvd_in_t w;
        int idle_set [4];
        int stall_set [4];
        idle_set = '{0, 72, 0, 34};
        stall_set = '{0, 0, 72, 34};
        for (int i = 0; i < TERMS_MAX; i++) shadow_coeff[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: zero count yields zero
        w.point = 32'h0001_0000; w.opcode = OP_VALUE; points_to_send.push_back(w);
        w.opcode = OP_DERIV; points_to_send.push_back(w);
        drain();

        // directed: full-scale coefficients, extreme and near-zero points, both operations
        for (int style = 1; style <= 2; style++)
        begin
            load_coeffs(7, style);
            foreach (idle_set[k])
                if (k < 2)
                begin
                    w.point = k ? 32'h7fff_ffff : 32'h8000_0000;
                    w.opcode = OP_VALUE; points_to_send.push_back(w);
                    w.opcode = OP_DERIV; points_to_send.push_back(w);
                end
            w.point = 32'h0; w.opcode = OP_DERIV; points_to_send.push_back(w);
            w.point = 32'hffff_ffff; w.opcode = OP_VALUE; points_to_send.push_back(w);
            drain();
        end
        // count of one: derivative is zero
        load_coeffs(1, 0);
        w.point = 32'h0002_0000; w.opcode = OP_DERIV; points_to_send.push_back(w);
        w.opcode = OP_VALUE; points_to_send.push_back(w);
        drain();

        // random phases over the idling profiles and several settings
        for (int ph = 0; ph < 16; ph++)
        begin
            send_idle_pct = idle_set[ph % 4];
            recv_stall_pct = stall_set[ph % 4];
            load_coeffs(ph == 0 ? 7 : (ph == 1 ? 0 : $urandom_range(7)), 0);
            for (int k = 0; k < 40; k++)
                points_to_send.push_back(rand_point());
            if (ph == 5)
            begin
                // sender holds off until every result is back, then resumes
                while (points_to_send.size() > 20) @(posedge clk);
                send_idle_pct = 100;
                while (poly_expected.size() > 0 || in_ch.valid) @(posedge clk);
                send_idle_pct = idle_set[ph % 4];
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        if (errors == 0)
            $display("PASS polynomial_value_and_derivative");
        else
            $display("FAIL polynomial_value_and_derivative");
        $finish;
    end
endmodule
`default_nettype wire
